@@ hdl/rtm_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the reference tone mixer.
// Has no dependencies. The interfaces and all modules use it by scoped names.
package rtm_pkg;

	localparam int NUM_CH          = 8;
	localparam int MAX_CHANNELS    = 8;
	localparam int CH_W            = $clog2(NUM_CH);
	localparam int SAMPLE_W        = 24;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
	localparam int QADDR_W         = SINE_TABLE_BITS - 1;
	localparam int MAG_W           = 23;

	localparam int FREQ_W = 14;
	localparam int GAIN_W = 15;
	localparam int DUR_W  = 24;
	localparam int RATE_W = 18;
	localparam int ACH_W  = 4;
	localparam int PHASE_W = 32;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Phase step numerator is freq * 2^32 plus half the rate; 47 bits cover it.
	localparam int DIV_BITS = FREQ_W + PHASE_W + 1;
	localparam int DCNT_W   = $clog2(DIV_BITS);

	localparam logic [FREQ_W-1:0] FREQ_MIN   = FREQ_W'(20);
	localparam logic [FREQ_W-1:0] FREQ_MAX   = FREQ_W'(12000);
	localparam logic [FREQ_W-1:0] FREQ_RST   = FREQ_W'(440);
	localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(16384);
	localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
	localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(192000);
	localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(48000);
	localparam logic [ACH_W-1:0]  ACH_MIN    = ACH_W'(1);
	localparam logic [ACH_W-1:0]  ACH_MAX    = ACH_W'(MAX_CHANNELS);
	localparam logic [ACH_W-1:0]  ACH_RST    = ACH_W'(2);

	typedef enum logic [2:0] {
		REG_FREQ     = 3'd0,
		REG_GAIN     = 3'd1,
		REG_DURATION = 3'd2,
		REG_RATE     = 3'd3,
		REG_CHANNELS = 3'd4
	} rtm_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOOKUP,
		ST_SCALE,
		ST_MIX,
		ST_DONE
	} rtm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rtm_div_status_t;

	typedef logic [MAG_W-1:0] qsine_t [0:QUARTER];

	// One Taylor term update; the divisor for term n is (2n)(2n+1).
	function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
		logic [63:0] r;
		case (n)
			1:       r = t / 6;
			2:       r = t / 20;
			3:       r = t / 42;
			4:       r = t / 72;
			5:       r = t / 110;
			6:       r = t / 156;
			7:       r = t / 210;
			default: r = t / 272;
		endcase
		return r;
	endfunction

	// Quarter-wave sine magnitudes in Q1.23, evaluated at elaboration.
	function automatic qsine_t build_qsine();
		qsine_t     tbl;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint     acc;
		for (int k = 0; k <= QUARTER; k++) begin
			x    = (64'd3373259426 * 64'(k) + 64'(QUARTER)) >> (SINE_TABLE_BITS - 1);
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = taylor_div((term * x2) >> 30, n);
				if ((n % 2) == 1) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			v = (64'(acc) + 64'd64) >> 7;
			if (v > 64'd8388607) v = 64'd8388607;
			tbl[k] = v[MAG_W-1:0];
		end
		return tbl;
	endfunction

	localparam qsine_t QSINE = build_qsine();

endpackage

@@ hdl/rtm_stream_if.sv @@
// Frame stream interfaces of the reference tone mixer: input frames and mixed output frames.
// Depends on rtm_pkg for the sample width.
interface rtm_in_if;
	logic valid;
	logic ready;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_0;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_1;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_2;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_3;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_4;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_5;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_6;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_in_7;
	logic start_tone;
	logic block_last;

	modport source (output valid, frame_in_0, frame_in_1, frame_in_2, frame_in_3,
		frame_in_4, frame_in_5, frame_in_6, frame_in_7, start_tone, block_last,
		input ready);
	modport sink (input valid, frame_in_0, frame_in_1, frame_in_2, frame_in_3,
		frame_in_4, frame_in_5, frame_in_6, frame_in_7, start_tone, block_last,
		output ready);
endinterface

interface rtm_out_if;
	logic valid;
	logic ready;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_0;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_1;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_2;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_3;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_4;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_5;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_6;
	logic signed [rtm_pkg::SAMPLE_W-1:0] frame_out_7;
	logic tone_active;
	logic block_end;

	modport source (output valid, frame_out_0, frame_out_1, frame_out_2, frame_out_3,
		frame_out_4, frame_out_5, frame_out_6, frame_out_7, tone_active, block_end,
		input ready);
	modport sink (input valid, frame_out_0, frame_out_1, frame_out_2, frame_out_3,
		frame_out_4, frame_out_5, frame_out_6, frame_out_7, tone_active, block_end,
		output ready);
endinterface

@@ hdl/rtm_step_div.sv @@
// Bit-serial restoring divider that derives the phase step from frequency and sample rate.
// Depends on rtm_pkg for widths.
module rtm_step_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rtm_pkg::FREQ_W-1:0]        freq,
	input  logic [rtm_pkg::RATE_W-1:0]        rate,
	output rtm_pkg::rtm_div_status_t          status,
	output logic [rtm_pkg::PHASE_W-1:0]       quot
);

	logic                              busy_q;
	logic [rtm_pkg::DCNT_W-1:0]        cnt_q;
	logic [rtm_pkg::DIV_BITS-1:0]      dvd_q;
	logic [rtm_pkg::RATE_W-1:0]        rem_q;
	logic [rtm_pkg::RATE_W-1:0]        rate_q;
	logic [rtm_pkg::PHASE_W-1:0]       quot_q;
	logic [rtm_pkg::RATE_W:0]          trial;
	logic                              ge;

	// One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, dvd_q[rtm_pkg::DIV_BITS-1]};
	assign ge    = trial >= {1'b0, rate_q};

	assign status.busy = busy_q;
	assign status.done = busy_q && (cnt_q == '0);
	assign quot        = {quot_q[rtm_pkg::PHASE_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= rtm_pkg::DCNT_W'(rtm_pkg::DIV_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {1'b0, freq, {rtm_pkg::PHASE_W{1'b0}}}
				+ rtm_pkg::DIV_BITS'(rate >> 1);
			rem_q  <= '0;
			rate_q <= rate;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= dvd_q << 1;
			rem_q  <= ge ? rtm_pkg::RATE_W'(trial - {1'b0, rate_q})
				: rtm_pkg::RATE_W'(trial);
			quot_q <= {quot_q[rtm_pkg::PHASE_W-2:0], ge};
		end
	end

endmodule

@@ hdl/reference_tone_mixer.sv @@
// Top level of the reference tone mixer: APB register file, sequencer and the shared
// mixing datapath. Depends on rtm_pkg, rtm_stream_if and rtm_step_div.
//
// Usage: each beat on in_ch carries one audio frame of eight Q1.23 samples plus a
// start_tone and a block_last flag. The block returns one beat on out_ch per input
// beat, with the tone added to the first active_channels channels while the tone
// lasts, saturated to 24 bits, and block_last echoed as block_end.
// The block works on one frame at a time. A frame without start_tone passes through
// the table lookup, the gain multiplier and the shared saturating adder (one channel
// a cycle), then loads the output register; a new frame is taken only once the
// previous one is loaded. A frame with start_tone first runs the bit-serial phase
// step divider (one quotient bit per cycle).
// The output register parts the two sides: a stalled receiver holds the finished
// beat, the block accepts and works on the next frame, and waits only when that one
// is done and the output register is still full.
// Reset clears the sequencer, the tone state (phase, step, frames left, gain) and
// loads the register reset values; no tone plays until a frame with start_tone.
// Registers are written over APB at byte address 4*index and read back clamped.
module reference_tone_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	rtm_in_if.sink                            in_ch,
	rtm_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rtm_pkg::PADDR_W-1:0]       paddr,
	input  logic [rtm_pkg::PDATA_W-1:0]       pwdata,
	output logic [rtm_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	// Configuration registers, held clamped into their legal ranges.
	logic [rtm_pkg::FREQ_W-1:0] freq_q;
	logic [rtm_pkg::GAIN_W-1:0] gain_q;
	logic [rtm_pkg::DUR_W-1:0]  dur_q;
	logic [rtm_pkg::RATE_W-1:0] rate_q;
	logic [rtm_pkg::ACH_W-1:0]  ach_q;

	rtm_pkg::rtm_reg_t          reg_idx;
	logic                       wr_en;
	logic [rtm_pkg::FREQ_W-1:0] wr_freq;
	logic [rtm_pkg::GAIN_W-1:0] wr_gain;
	logic [rtm_pkg::RATE_W-1:0] wr_rate;
	logic [rtm_pkg::ACH_W-1:0]  wr_ach;

	// Tone state.
	logic [rtm_pkg::PHASE_W-1:0] phase_q;
	logic [rtm_pkg::PHASE_W-1:0] step_q;
	logic [rtm_pkg::DUR_W-1:0]   left_q;
	logic [rtm_pkg::GAIN_W-1:0]  lgain_q;

	// Working registers of the frame in flight.
	logic signed [rtm_pkg::SAMPLE_W-1:0] smp_q [0:rtm_pkg::NUM_CH-1];
	logic                                last_q;
	logic                                active_q;
	logic                                neg_q;
	logic [rtm_pkg::MAG_W-1:0]           mag_q;
	logic signed [rtm_pkg::SAMPLE_W-1:0] tone_q;
	logic [rtm_pkg::CH_W-1:0]            ch_q;

	// Output register.
	logic                                out_valid_q;
	logic signed [rtm_pkg::SAMPLE_W-1:0] out_smp_q [0:rtm_pkg::NUM_CH-1];
	logic                                out_active_q;
	logic                                out_last_q;

	rtm_pkg::rtm_state_t state_q;
	rtm_pkg::rtm_state_t state_d;
	logic                div_start;
	logic                out_load;
	logic                in_take;

	rtm_pkg::rtm_div_status_t    div_status;
	logic [rtm_pkg::PHASE_W-1:0] div_quot;

	// Lookup and arithmetic nets.
	logic [rtm_pkg::SINE_TABLE_BITS-1:0] tbl_idx;
	logic [rtm_pkg::QADDR_W-1:0]         tbl_addr;
	logic [2*rtm_pkg::MAG_W-1:0]         prod;
	logic [rtm_pkg::MAG_W-1:0]           scaled;
	logic signed [rtm_pkg::SAMPLE_W:0]   sum;
	logic signed [rtm_pkg::SAMPLE_W-1:0] mixed;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_idx = rtm_pkg::rtm_reg_t'(paddr[rtm_pkg::PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_comb begin
		wr_freq = pwdata[rtm_pkg::FREQ_W-1:0];
		if (wr_freq < rtm_pkg::FREQ_MIN) wr_freq = rtm_pkg::FREQ_MIN;
		else if (wr_freq > rtm_pkg::FREQ_MAX) wr_freq = rtm_pkg::FREQ_MAX;
		wr_gain = pwdata[rtm_pkg::GAIN_W-1:0];
		if (wr_gain > rtm_pkg::GAIN_MAX) wr_gain = rtm_pkg::GAIN_MAX;
		wr_rate = pwdata[rtm_pkg::RATE_W-1:0];
		if (wr_rate < rtm_pkg::RATE_MIN) wr_rate = rtm_pkg::RATE_MIN;
		else if (wr_rate > rtm_pkg::RATE_MAX) wr_rate = rtm_pkg::RATE_MAX;
		wr_ach = pwdata[rtm_pkg::ACH_W-1:0];
		if (wr_ach < rtm_pkg::ACH_MIN) wr_ach = rtm_pkg::ACH_MIN;
		else if (wr_ach > rtm_pkg::ACH_MAX) wr_ach = rtm_pkg::ACH_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= rtm_pkg::FREQ_RST;
			gain_q <= '0;
			dur_q  <= '0;
			rate_q <= rtm_pkg::RATE_RST;
			ach_q  <= rtm_pkg::ACH_RST;
		end else if (wr_en) begin
			case (reg_idx)
				rtm_pkg::REG_FREQ:     freq_q <= wr_freq;
				rtm_pkg::REG_GAIN:     gain_q <= wr_gain;
				rtm_pkg::REG_DURATION: dur_q  <= pwdata[rtm_pkg::DUR_W-1:0];
				rtm_pkg::REG_RATE:     rate_q <= wr_rate;
				rtm_pkg::REG_CHANNELS: ach_q  <= wr_ach;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rtm_pkg::REG_FREQ:     prdata = rtm_pkg::PDATA_W'(freq_q);
			rtm_pkg::REG_GAIN:     prdata = rtm_pkg::PDATA_W'(gain_q);
			rtm_pkg::REG_DURATION: prdata = rtm_pkg::PDATA_W'(dur_q);
			rtm_pkg::REG_RATE:     prdata = rtm_pkg::PDATA_W'(rate_q);
			rtm_pkg::REG_CHANNELS: prdata = rtm_pkg::PDATA_W'(ach_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- Divider
	// Only a frame that starts a tone needs the phase step, so the divider runs
	// once per start and the sequencer waits for it.
	rtm_step_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.freq   (freq_q),
		.rate   (rate_q),
		.status (div_status),
		.quot   (div_quot)
	);

	// ---------------------------------------------------------------- Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rtm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		out_load    = 1'b0;
		in_ch.ready = 1'b0;
		case (state_q)
			rtm_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (in_ch.start_tone) begin
						div_start = 1'b1;
						state_d   = rtm_pkg::ST_DIV;
					end else begin
						state_d = rtm_pkg::ST_LOOKUP;
					end
				end
			end
			rtm_pkg::ST_DIV: begin
				if (div_status.done) state_d = rtm_pkg::ST_LOOKUP;
			end
			rtm_pkg::ST_LOOKUP: state_d = rtm_pkg::ST_SCALE;
			rtm_pkg::ST_SCALE:  state_d = rtm_pkg::ST_MIX;
			rtm_pkg::ST_MIX: begin
				if (ch_q == rtm_pkg::CH_W'(rtm_pkg::NUM_CH - 1)) state_d = rtm_pkg::ST_DONE;
			end
			rtm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = rtm_pkg::ST_IDLE;
				end
			end
			default: state_d = rtm_pkg::ST_IDLE;
		endcase
	end

	assign in_take = in_ch.valid && in_ch.ready;

	// ---------------------------------------------------------------- Tone state
	// The phase's top bits pick the quadrant and the table entry; odd quadrants
	// read the table backwards, the upper half of the cycle negates.
	assign tbl_idx  = phase_q[rtm_pkg::PHASE_W-1 -: rtm_pkg::SINE_TABLE_BITS];
	assign tbl_addr = tbl_idx[rtm_pkg::SINE_TABLE_BITS-2]
		? rtm_pkg::QADDR_W'(rtm_pkg::QUARTER)
			- {1'b0, tbl_idx[rtm_pkg::SINE_TABLE_BITS-3:0]}
		: {1'b0, tbl_idx[rtm_pkg::SINE_TABLE_BITS-3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			left_q  <= '0;
			lgain_q <= '0;
		end else begin
			if (in_take && in_ch.start_tone) begin
				phase_q <= '0;
				left_q  <= dur_q;
				lgain_q <= gain_q;
			end else if (state_q == rtm_pkg::ST_LOOKUP && left_q != '0) begin
				phase_q <= phase_q + step_q;
				left_q  <= left_q - 1'b1;
			end
			if (state_q == rtm_pkg::ST_DIV && div_status.done) step_q <= div_quot;
		end
	end

	// ---------------------------------------------------------------- Datapath
	// Gain scaling rounds half away from zero on the magnitude before the sign.
	assign prod   = (2*rtm_pkg::MAG_W)'(mag_q) * (2*rtm_pkg::MAG_W)'(lgain_q)
		+ (2*rtm_pkg::MAG_W)'(32768);
	assign scaled = prod[16 +: rtm_pkg::MAG_W];

	// The shared saturating adder always works on channel slot zero; the frame
	// rotates one slot per cycle so that all eight pass through it in order.
	assign sum   = {smp_q[0][rtm_pkg::SAMPLE_W-1], smp_q[0]}
		+ {tone_q[rtm_pkg::SAMPLE_W-1], tone_q};
	always_comb begin
		if (!active_q || ({1'b0, ch_q} >= ach_q)) begin
			mixed = smp_q[0];
		end else if (sum[rtm_pkg::SAMPLE_W] != sum[rtm_pkg::SAMPLE_W-1]) begin
			mixed = sum[rtm_pkg::SAMPLE_W]
				? {1'b1, {(rtm_pkg::SAMPLE_W-1){1'b0}}}
				: {1'b0, {(rtm_pkg::SAMPLE_W-1){1'b1}}};
		end else begin
			mixed = sum[rtm_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rtm_pkg::ST_IDLE: begin
				if (in_take) begin
					smp_q[0] <= in_ch.frame_in_0;
					smp_q[1] <= in_ch.frame_in_1;
					smp_q[2] <= in_ch.frame_in_2;
					smp_q[3] <= in_ch.frame_in_3;
					smp_q[4] <= in_ch.frame_in_4;
					smp_q[5] <= in_ch.frame_in_5;
					smp_q[6] <= in_ch.frame_in_6;
					smp_q[7] <= in_ch.frame_in_7;
					last_q   <= in_ch.block_last;
				end
			end
			rtm_pkg::ST_LOOKUP: begin
				active_q <= left_q != '0;
				neg_q    <= tbl_idx[rtm_pkg::SINE_TABLE_BITS-1];
				mag_q    <= rtm_pkg::QSINE[tbl_addr];
			end
			rtm_pkg::ST_SCALE: begin
				ch_q <= '0;
				if (!active_q) tone_q <= '0;
				else if (neg_q) tone_q <= -$signed({1'b0, scaled});
				else tone_q <= $signed({1'b0, scaled});
			end
			rtm_pkg::ST_MIX: begin
				for (int i = 0; i < rtm_pkg::NUM_CH - 1; i++) smp_q[i] <= smp_q[i+1];
				smp_q[rtm_pkg::NUM_CH-1] <= mixed;
				ch_q <= ch_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- Output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < rtm_pkg::NUM_CH; i++) out_smp_q[i] <= smp_q[i];
			out_active_q <= active_q;
			out_last_q   <= last_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.frame_out_0 = out_smp_q[0];
	assign out_ch.frame_out_1 = out_smp_q[1];
	assign out_ch.frame_out_2 = out_smp_q[2];
	assign out_ch.frame_out_3 = out_smp_q[3];
	assign out_ch.frame_out_4 = out_smp_q[4];
	assign out_ch.frame_out_5 = out_smp_q[5];
	assign out_ch.frame_out_6 = out_smp_q[6];
	assign out_ch.frame_out_7 = out_smp_q[7];
	assign out_ch.tone_active = out_active_q;
	assign out_ch.block_end   = out_last_q;

	// ---------------------------------------------------------------- Assertions
	// A frame that is played counts the remaining length down by exactly one.
	a_left_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtm_pkg::ST_LOOKUP && left_q != '0) |=> left_q == $past(left_q) - 1'b1)
		else $error("frames left did not count down by one");

	// Starting a tone clears the phase before the first lookup.
	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_ch.start_tone) |=> phase_q == '0)
		else $error("phase not cleared on tone start");

	// A fresh output beat comes only from the finishing step of the sequencer.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rtm_pkg::ST_DONE))
		else $error("output beat raised outside the finishing step");

	// With no tone playing, the adder sees a zero tone sample.
	a_silent_tone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtm_pkg::ST_MIX && !active_q) |-> tone_q == '0)
		else $error("nonzero tone while no tone is active");

	// The divider runs exactly while the sequencer waits for the phase step.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.busy == (state_q == rtm_pkg::ST_DIV))
		else $error("divider activity does not match the sequencer");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for reference_tone_mixer: frame streams, APB registers and tone mixing.
// Depends on rtm_pkg, rtm_in_if, rtm_out_if and the reference_tone_mixer RTL.
module testbench;

	// Register count on the APB port and the number of decodable register slots.
	localparam int NUM_REGS  = int'(rtm_pkg::REG_CHANNELS) + 1;
	localparam int REG_SLOTS = 1 << $bits(rtm_pkg::rtm_reg_t);

	localparam int ITEM_TARGET = 1650;
	localparam int DRAIN_CYCLES = 80;

	localparam logic [rtm_pkg::SAMPLE_W-1:0] SAMPLE_HI = 24'h7FFFFF;
	localparam logic [rtm_pkg::SAMPLE_W-1:0] SAMPLE_LO = 24'h800000;
	localparam longint SAT_HI = 8388607;
	localparam longint SAT_LO = -8388608;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// One input beat and one output beat, both as the fields of the streams.
	typedef struct packed {
		logic [rtm_pkg::NUM_CH-1:0][rtm_pkg::SAMPLE_W-1:0] smp;
		logic start;
		logic last;
	} audio_frame_t;

	typedef struct packed {
		logic [rtm_pkg::NUM_CH-1:0][rtm_pkg::SAMPLE_W-1:0] smp;
		logic active;
		logic last;
	} mixed_frame_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rtm_pkg::PADDR_W-1:0] paddr;
	logic [rtm_pkg::PDATA_W-1:0] pwdata;
	logic [rtm_pkg::PDATA_W-1:0] prdata;
	logic pready;

	rtm_in_if  in_ch ();
	rtm_out_if out_ch ();

	reference_tone_mixer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the register file, already clamped the way the block clamps on write.
	logic [rtm_pkg::FREQ_W-1:0] freq_hz;
	logic [rtm_pkg::GAIN_W-1:0] gain_q16;
	logic [rtm_pkg::DUR_W-1:0]  duration_frames;
	logic [rtm_pkg::RATE_W-1:0] rate_hz;
	logic [rtm_pkg::ACH_W-1:0]  channel_count;

	// Tone generator state as it is after the last accepted frame.
	logic [rtm_pkg::PHASE_W-1:0] tone_phase;
	logic [rtm_pkg::PHASE_W-1:0] tone_step;
	logic [rtm_pkg::DUR_W-1:0]   tone_frames_left;
	logic [rtm_pkg::GAIN_W-1:0]  tone_gain;

	logic [rtm_pkg::MAG_W-1:0] sine_mag [0:rtm_pkg::QUARTER];

	mixed_frame_t expected_mixes [$];
	int mismatches;
	int frames_sent;
	int burst_left;
	int stall_mode;
	int stall_cycles_left;

	logic [rtm_pkg::NUM_CH-1:0][rtm_pkg::SAMPLE_W-1:0] mixed_samples;
	assign mixed_samples = {out_ch.frame_out_7, out_ch.frame_out_6, out_ch.frame_out_5,
		out_ch.frame_out_4, out_ch.frame_out_3, out_ch.frame_out_2, out_ch.frame_out_1,
		out_ch.frame_out_0};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Quarter-wave magnitudes in Q1.23. The angle pi*k/2^(bits-1) is formed in Q30 and the
	// sine is summed as a Taylor series of nine terms, each divided down from the last.
	function automatic void build_sine_table();
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint acc;
		for (int k = 0; k <= rtm_pkg::QUARTER; k++) begin
			x = (PI_Q30 * 64'(k) + (64'd1 << (rtm_pkg::SINE_TABLE_BITS - 2)))
				>> (rtm_pkg::SINE_TABLE_BITS - 1);
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
				if ((n % 2) == 1) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			v = (64'(acc) + 64'd64) >> 7;
			sine_mag[k] = (v > 64'd8388607) ? 23'h7FFFFF : v[rtm_pkg::MAG_W-1:0];
		end
	endfunction

	function automatic logic [31:0] clamp_value(input logic [31:0] v, input logic [31:0] lo,
		input logic [31:0] hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Registers keep only their own width of the written word, then saturate into range.
	// Writes to slots past the last register change nothing.
	function automatic void store_register(input logic [2:0] idx, input logic [31:0] v);
		case (idx)
			rtm_pkg::REG_FREQ:
				freq_hz = rtm_pkg::FREQ_W'(clamp_value(32'(v[rtm_pkg::FREQ_W-1:0]),
					32'(rtm_pkg::FREQ_MIN), 32'(rtm_pkg::FREQ_MAX)));
			rtm_pkg::REG_GAIN:
				gain_q16 = rtm_pkg::GAIN_W'(clamp_value(32'(v[rtm_pkg::GAIN_W-1:0]), 0,
					32'(rtm_pkg::GAIN_MAX)));
			rtm_pkg::REG_DURATION: duration_frames = v[rtm_pkg::DUR_W-1:0];
			rtm_pkg::REG_RATE:
				rate_hz = rtm_pkg::RATE_W'(clamp_value(32'(v[rtm_pkg::RATE_W-1:0]),
					32'(rtm_pkg::RATE_MIN), 32'(rtm_pkg::RATE_MAX)));
			rtm_pkg::REG_CHANNELS:
				channel_count = rtm_pkg::ACH_W'(clamp_value(32'(v[rtm_pkg::ACH_W-1:0]),
					32'(rtm_pkg::ACH_MIN), 32'(rtm_pkg::ACH_MAX)));
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] register_shadow(input logic [2:0] idx);
		case (idx)
			rtm_pkg::REG_FREQ:     return 32'(freq_hz);
			rtm_pkg::REG_GAIN:     return 32'(gain_q16);
			rtm_pkg::REG_DURATION: return 32'(duration_frames);
			rtm_pkg::REG_RATE:     return 32'(rate_hz);
			rtm_pkg::REG_CHANNELS: return 32'(channel_count);
			default:               return '0;
		endcase
	endfunction

	// Signed tone sample at the current phase: the top phase bits pick a quadrant and a
	// table entry (mirrored in odd quadrants, negated in the upper half of the phase).
	function automatic longint tone_level();
		logic [rtm_pkg::SINE_TABLE_BITS-1:0] idx;
		logic [1:0] quad;
		logic [rtm_pkg::SINE_TABLE_BITS-3:0] q;
		longint mag;
		longint scaled;
		idx = tone_phase[rtm_pkg::PHASE_W-1 -: rtm_pkg::SINE_TABLE_BITS];
		quad = idx[rtm_pkg::SINE_TABLE_BITS-1 -: 2];
		q = idx[rtm_pkg::SINE_TABLE_BITS-3:0];
		mag = quad[0] ? longint'(sine_mag[rtm_pkg::QUARTER - int'(q)])
			: longint'(sine_mag[q]);
		scaled = (mag * longint'(tone_gain) + 32768) >>> 16;
		return quad[1] ? -scaled : scaled;
	endfunction

	// Works out the mixed frame for one accepted input frame and advances the tone state.
	function automatic mixed_frame_t mix_frame(input audio_frame_t f);
		mixed_frame_t r;
		longint tone;
		longint s;
		logic on;
		if (f.start) begin
			tone_step = rtm_pkg::PHASE_W'(((64'(freq_hz) << 32) + 64'(rate_hz >> 1))
				/ 64'(rate_hz));
			tone_phase = '0;
			tone_frames_left = duration_frames;
			tone_gain = gain_q16;
		end
		on = (tone_frames_left != 0);
		tone = 0;
		if (on) begin
			tone = tone_level();
			tone_phase = tone_phase + tone_step;
			tone_frames_left = tone_frames_left - 1'b1;
		end
		for (int ch = 0; ch < rtm_pkg::NUM_CH; ch++) begin
			s = longint'($signed(f.smp[ch]));
			if (on && ch < int'(channel_count) && ch < rtm_pkg::MAX_CHANNELS) begin
				s = s + tone;
				if (s > SAT_HI) s = SAT_HI;
				if (s < SAT_LO) s = SAT_LO;
			end
			r.smp[ch] = rtm_pkg::SAMPLE_W'(s);
		end
		r.active = on;
		r.last = f.last;
		return r;
	endfunction

	function automatic audio_frame_t random_frame(input int start_odds);
		audio_frame_t f;
		for (int ch = 0; ch < rtm_pkg::NUM_CH; ch++) begin
			case ($urandom_range(0, 9))
				0:       f.smp[ch] = SAMPLE_HI;
				1:       f.smp[ch] = SAMPLE_LO;
				2:       f.smp[ch] = '0;
				default: f.smp[ch] = rtm_pkg::SAMPLE_W'($urandom);
			endcase
		end
		f.start = (start_odds != 0) && ($urandom_range(1, start_odds) == 1);
		f.last = ($urandom_range(0, 7) == 0);
		return f;
	endfunction

	// Register values for a random phase: the range limits, values past them in both
	// directions, whole random words and, most often, something inside the range.
	function automatic logic [31:0] pick_register_value(input logic [2:0] idx);
		int unsigned sel;
		sel = $urandom_range(0, 7);
		case (idx)
			rtm_pkg::REG_FREQ:
				case (sel)
					0:       return 32'd0;
					1:       return 32'(rtm_pkg::FREQ_MIN);
					2:       return 32'(rtm_pkg::FREQ_MAX);
					3:       return 32'h3FFF;
					4:       return $urandom;
					default: return $urandom_range(20, 12000);
				endcase
			rtm_pkg::REG_GAIN:
				case (sel)
					0:       return 32'd0;
					1:       return 32'(rtm_pkg::GAIN_MAX);
					2:       return 32'h7FFF;
					3:       return $urandom;
					default: return $urandom_range(0, 16384);
				endcase
			rtm_pkg::REG_DURATION:
				case (sel)
					0:       return 32'd0;
					1:       return 32'hFFFFFF;
					2:       return $urandom;
					3:       return 32'd1;
					default: return $urandom_range(1, 300);
				endcase
			rtm_pkg::REG_RATE:
				case (sel)
					0:       return 32'd0;
					1:       return 32'(rtm_pkg::RATE_MIN);
					2:       return 32'(rtm_pkg::RATE_MAX);
					3:       return 32'h3FFFF;
					4:       return $urandom;
					default: return $urandom_range(8000, 192000);
				endcase
			default:
				case (sel)
					0:       return 32'd0;
					1:       return 32'(rtm_pkg::ACH_MIN);
					2:       return 32'(rtm_pkg::ACH_MAX);
					3:       return 32'hF;
					4:       return $urandom;
					default: return $urandom_range(1, 8);
				endcase
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input longint want,
		input longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		mismatches++;
	endfunction

	// APB write: setup cycle, then the access cycle; the register takes the value at the
	// edge where the access completes. The bus returns to idle after each transfer.
	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		store_register(idx, value);
		@(posedge clk);
	endtask

	task automatic read_register(input logic [2:0] idx, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reads every register back and compares with the clamped shadow copy.
	task automatic check_registers();
		logic [31:0] got;
		for (int i = 0; i < NUM_REGS; i++) begin
			read_register(3'(i), got);
			if (got !== register_shadow(3'(i)))
				note_mismatch($sformatf("register %0d readback", i),
					longint'(register_shadow(3'(i))), longint'(got));
		end
	endtask

	// Sends one frame. The sender runs in bursts of random length; before a new burst it
	// usually drops valid for a random gap, so gaps land on every step of the block's work.
	// The expectation is computed when the frame is accepted.
	task automatic send_frame(input audio_frame_t f);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.frame_in_0 <= f.smp[0];
		in_ch.frame_in_1 <= f.smp[1];
		in_ch.frame_in_2 <= f.smp[2];
		in_ch.frame_in_3 <= f.smp[3];
		in_ch.frame_in_4 <= f.smp[4];
		in_ch.frame_in_5 <= f.smp[5];
		in_ch.frame_in_6 <= f.smp[6];
		in_ch.frame_in_7 <= f.smp[7];
		in_ch.start_tone <= f.start;
		in_ch.block_last <= f.last;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		expected_mixes = {expected_mixes, mix_frame(f)};
		frames_sent++;
	endtask

	// Holds the sender off until every outstanding frame has come back, leaving the block
	// idle for register writes.
	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_mixes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Straight after reset: gain and duration are zero, so even a start leaves the samples
	// untouched, which also covers a start with zero duration.
	task automatic test_passthrough_after_reset();
		audio_frame_t f;
		f = random_frame(0);
		f.smp = {rtm_pkg::NUM_CH{SAMPLE_HI}};
		f.start = 1'b1;
		f.last = 1'b0;
		send_frame(f);
		f.smp = {rtm_pkg::NUM_CH{SAMPLE_LO}};
		f.start = 1'b0;
		f.last = 1'b1;
		send_frame(f);
		send_frame(random_frame(0));
		wait_for_results();
	endtask

	// Each register gets values below and above its range and is read back clamped.
	// Writes to the spare slots must leave every register alone.
	task automatic test_register_clamping();
		for (int i = 0; i < NUM_REGS; i++) begin
			write_register(3'(i), 32'd0);
			check_registers();
			write_register(3'(i), 32'hFFFFFFFF);
			check_registers();
			write_register(3'(i), pick_register_value(3'(i)));
		end
		for (int i = NUM_REGS; i < REG_SLOTS; i++)
			write_register(3'(i), $urandom);
		check_registers();
	endtask

	// Highest frequency at the highest rate and full gain on all eight channels. Channels
	// alternate between full scale positive and negative so that the tone peaks saturate
	// both ways. A second start lands while the tone is still running and restarts it.
	task automatic test_saturation_and_restart();
		audio_frame_t f;
		write_register(rtm_pkg::REG_FREQ, 32'h3FFF);
		write_register(rtm_pkg::REG_RATE, 32'h3FFFF);
		write_register(rtm_pkg::REG_GAIN, 32'h7FFF);
		write_register(rtm_pkg::REG_DURATION, 32'd16);
		write_register(rtm_pkg::REG_CHANNELS, 32'hF);
		check_registers();
		for (int i = 0; i < 12; i++) begin
			f = random_frame(0);
			for (int ch = 0; ch < rtm_pkg::NUM_CH; ch++)
				f.smp[ch] = (((ch + i) % 2) == 1) ? SAMPLE_LO : SAMPLE_HI;
			f.start = (i == 0) || (i == 8);
			f.last = ((i % 4) == 3);
			send_frame(f);
		end
		wait_for_results();
	endtask

	// Lowest frequency and rate, a single channel and a two-frame tone: the third and
	// fourth frames come after the tone has ended.
	task automatic test_short_single_channel_tone();
		audio_frame_t f;
		write_register(rtm_pkg::REG_FREQ, 32'd0);
		write_register(rtm_pkg::REG_RATE, 32'(rtm_pkg::RATE_MIN));
		write_register(rtm_pkg::REG_GAIN, 32'(rtm_pkg::GAIN_MAX));
		write_register(rtm_pkg::REG_DURATION, 32'd2);
		write_register(rtm_pkg::REG_CHANNELS, 32'd0);
		check_registers();
		for (int i = 0; i < 4; i++) begin
			f = random_frame(0);
			f.start = (i == 0);
			send_frame(f);
		end
		wait_for_results();
	endtask

	// Random phases: the stream drains, registers are rewritten and read back, then a run
	// of frames follows that usually opens with a start and restarts now and then.
	task automatic test_random_traffic();
		audio_frame_t f;
		int phase_len;
		while (frames_sent < ITEM_TARGET) begin
			wait_for_results();
			for (int i = 0; i < NUM_REGS; i++)
				if ($urandom_range(0, 3) != 0) write_register(3'(i), pick_register_value(3'(i)));
			check_registers();
			phase_len = $urandom_range(30, 120);
			for (int i = 0; i < phase_len; i++) begin
				f = random_frame(48);
				if (i == 0) f.start = ($urandom_range(0, 3) != 0);
				send_frame(f);
			end
		end
	endtask

	// The receiver switches between patterns: always ready, coin flips, long stalls with
	// rare ready cycles, and a short fixed rhythm.
	always @(posedge clk) begin
		if (stall_cycles_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_cycles_left = $urandom_range(50, 300);
		end else begin
			stall_cycles_left--;
		end
		case (stall_mode)
			0:       out_ch.ready <= 1'b1;
			1:       out_ch.ready <= 1'($urandom_range(0, 1));
			2:       out_ch.ready <= ($urandom_range(0, 9) == 0);
			default: out_ch.ready <= ((stall_cycles_left % 5) < 2);
		endcase
	end

	// Every output beat is compared field by field with the oldest expected frame.
	always @(posedge clk) begin : check_mixed_output
		mixed_frame_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_mixes.size() == 0) begin
				$display("%0t: output beat with no frame outstanding, expected none, actual %h",
					$time, mixed_samples);
				mismatches++;
			end else begin
				want = expected_mixes.pop_front();
				for (int ch = 0; ch < rtm_pkg::NUM_CH; ch++)
					if (mixed_samples[ch] !== want.smp[ch])
						note_mismatch($sformatf("frame_out_%0d", ch), longint'($signed(want.smp[ch])),
							longint'($signed(mixed_samples[ch])));
				if (out_ch.tone_active !== want.active)
					note_mismatch("tone_active", longint'(want.active), longint'(out_ch.tone_active));
				if (out_ch.block_end !== want.last)
					note_mismatch("block_end", longint'(want.last), longint'(out_ch.block_end));
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.frame_in_0 = '0;
		in_ch.frame_in_1 = '0;
		in_ch.frame_in_2 = '0;
		in_ch.frame_in_3 = '0;
		in_ch.frame_in_4 = '0;
		in_ch.frame_in_5 = '0;
		in_ch.frame_in_6 = '0;
		in_ch.frame_in_7 = '0;
		in_ch.start_tone = 1'b0;
		in_ch.block_last = 1'b0;
		out_ch.ready = 1'b0;
		mismatches = 0;
		frames_sent = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_cycles_left = 0;

		// Register reset values and a silent tone generator, as the block comes out of reset.
		build_sine_table();
		freq_hz = rtm_pkg::FREQ_RST;
		gain_q16 = '0;
		duration_frames = '0;
		rate_hz = rtm_pkg::RATE_RST;
		channel_count = rtm_pkg::ACH_RST;
		tone_phase = '0;
		tone_step = '0;
		tone_frames_left = '0;
		tone_gain = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough_after_reset();
		test_register_clamping();
		test_saturation_and_restart();
		test_short_single_channel_tone();
		test_random_traffic();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// A correct run needs well under a tenth of this, even with the slowest stall patterns
	// and a phase step division on every frame.
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
